// ===== rtl/rfstm_pkg.sv =====
package rfstm_pkg;

    localparam int GROUP_SIZE = 8;
    localparam int CNT_W      = 3;
    localparam int OFF_W      = 16;
    localparam int STR_W      = 8;
    localparam int SLOT_W     = 4;

    localparam logic [CNT_W-1:0] CNT_LAST  = 3'd7;
    localparam logic [CNT_W-1:0] STEP_LAST = 3'd7;
    localparam logic [CNT_W-1:0] PASS_LAST = 3'd6;
    localparam logic [CNT_W-1:0] MID_FIRST = 3'd2;
    localparam logic [CNT_W-1:0] MID_LAST  = 3'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SORT,
        S_SUM,
        S_FIN
    } t_state;

    typedef enum logic [2:0] {
        SOP_HOLD,
        SOP_LOAD,
        SOP_SWAP,
        SOP_ROTATE,
        SOP_ACCUM
    } t_sort_op;

    typedef struct packed {
        t_sort_op op;
        logic     direct;
        logic     fin;
    } t_seq_ctl;

endpackage

// ===== rtl/rfstm_if.sv =====
interface rfstm_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] freq_offset;
    logic signed [15:0] signal_strength;

    modport source (output valid, output freq_offset, output signal_strength, input ready);
    modport sink (input valid, input freq_offset, input signal_strength, output ready);
endinterface

interface rfstm_out_if;
    logic               valid;
    logic               ready;
    logic               group_done;
    logic signed [7:0]  strength_mean;
    logic signed [15:0] offset_mean;
    logic [3:0]         ring_slot;
    logic               data_ready;

    modport source (
        output valid, output group_done, output strength_mean, output offset_mean,
        output ring_slot, output data_ready, input ready
    );
    modport sink (
        input valid, input group_done, input strength_mean, input offset_mean,
        input ring_slot, input data_ready, output ready
    );
endinterface

// ===== rtl/rfstm_sorter.sv =====
module rfstm_sorter
    import rfstm_pkg::*;
#(
    parameter int W = 16
) (
    input  logic                i_clk,
    input  t_sort_op            i_op,
    input  logic signed [W-1:0] i_din,
    output logic signed [W-1:0] o_mean
);

    // The compare-exchange works on fixed positions only: the larger value is
    // carried at the head while the smaller one goes to the tail, so eight
    // steps make one bubble pass of the rotating buffer.
    logic signed [W-1:0] r_a [GROUP_SIZE];
    logic signed [W-1:0] n_a [GROUP_SIZE];
    logic signed [W+1:0] r_acc;
    logic signed [W+1:0] n_acc;
    logic                w_swap;

    assign w_swap = r_a[0] > r_a[1];

    always_comb begin
        n_acc = r_acc;
        for (int i = 0; i < GROUP_SIZE; i++) begin
            n_a[i] = r_a[i];
        end
        case (i_op)
            SOP_LOAD: begin
                for (int i = 0; i < GROUP_SIZE - 1; i++) begin
                    n_a[i] = r_a[i+1];
                end
                n_a[GROUP_SIZE-1] = i_din;
                n_acc = '0;
            end
            SOP_SWAP: begin
                for (int i = 1; i < GROUP_SIZE - 1; i++) begin
                    n_a[i] = r_a[i+1];
                end
                n_a[0]            = w_swap ? r_a[0] : r_a[1];
                n_a[GROUP_SIZE-1] = w_swap ? r_a[1] : r_a[0];
            end
            SOP_ROTATE, SOP_ACCUM: begin
                for (int i = 0; i < GROUP_SIZE - 1; i++) begin
                    n_a[i] = r_a[i+1];
                end
                n_a[GROUP_SIZE-1] = r_a[0];
                if (i_op == SOP_ACCUM) begin
                    n_acc = r_acc + {{2{r_a[0][W-1]}}, r_a[0]};
                end
            end
            default: begin
                n_acc = r_acc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < GROUP_SIZE; i++) begin
            r_a[i] <= n_a[i];
        end
        r_acc <= n_acc;
    end

    // Dropping the two low bits of the two's complement sum rounds to minus infinity.
    assign o_mean = r_acc[W+1:2];

endmodule

// ===== rtl/rfstm_seq.sv =====
module rfstm_seq
    import rfstm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    output logic     o_idle,
    output t_seq_ctl o_ctl
);

    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_step;
    logic [CNT_W-1:0]  r_pass;

    assign o_idle = r_state == S_IDLE;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_accept && r_cnt == CNT_LAST) begin
                    n_state = S_SORT;
                end
            end
            S_SORT: begin
                if (r_step == STEP_LAST && r_pass == PASS_LAST) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (r_step == STEP_LAST) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctl = '{op: SOP_HOLD, direct: 1'b0, fin: 1'b0};
        case (r_state)
            S_IDLE: begin
                o_ctl.op     = i_accept ? SOP_LOAD : SOP_HOLD;
                o_ctl.direct = i_accept && r_cnt != CNT_LAST;
            end
            S_SORT: begin
                o_ctl.op = (r_step == STEP_LAST) ? SOP_ROTATE : SOP_SWAP;
            end
            S_SUM: begin
                o_ctl.op = (r_step >= MID_FIRST && r_step <= MID_LAST) ? SOP_ACCUM
                                                                      : SOP_ROTATE;
            end
            S_FIN: begin
                o_ctl.fin = 1'b1;
            end
            default: begin
                o_ctl.op = SOP_HOLD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_step  <= '0;
            r_pass  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_accept) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_state == S_SORT || r_state == S_SUM) begin
                r_step <= r_step + 1'b1;
            end else begin
                r_step <= '0;
            end
            if (r_state == S_SORT) begin
                if (r_step == STEP_LAST) begin
                    r_pass <= r_pass + 1'b1;
                end
            end else begin
                r_pass <= '0;
            end
        end
    end

endmodule

// ===== rtl/rf_sample_trimmed_mean_unit.sv =====
// Interquartile mean of radio packet samples in groups of eight. Every input
// transaction gives exactly one output transaction. The first seven samples of
// a group are answered in the cycle after acceptance with group_done low and
// zero means. The eighth sample starts a sort of both channels on one shared
// compare-exchange step per channel (seven bubble passes), an accumulate of
// ranks two to five and a final state to register the result; input ready
// stays low meanwhile, so no new sample is taken while a group is processed.
// Means are floored, and the slot index wraps after RING_DEPTH groups, at
// which point data_ready sets and stays set until reset.
module rf_sample_trimmed_mean_unit
    import rfstm_pkg::*;
#(
    parameter int RING_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rfstm_in_if.sink    i_in,
    rfstm_out_if.source o_out
);

    localparam int GW = $clog2(RING_DEPTH);

    t_seq_ctl                   w_ctl;
    logic                       w_idle;
    logic                       w_accept;
    logic                       w_drain;
    logic                       w_wrap;
    logic signed [OFF_W-1:0]    w_off_mean;
    logic signed [STR_W-1:0]    w_str_mean;

    logic                       r_out_valid;
    logic                       r_done;
    logic signed [STR_W-1:0]    r_str_mean;
    logic signed [OFF_W-1:0]    r_off_mean;
    logic [SLOT_W-1:0]          r_slot;
    logic                       r_ready_out;
    logic [GW-1:0]              r_group;
    logic                       r_flag;

    logic signed [STR_W-1:0]    r_str_ring [RING_DEPTH];
    logic signed [OFF_W-1:0]    r_off_ring [RING_DEPTH];

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_drain    = o_out.valid && o_out.ready;
    assign i_in.ready = w_idle && (!r_out_valid || o_out.ready);
    assign w_wrap     = r_group == GW'(RING_DEPTH - 1);

    rfstm_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .o_idle   (w_idle),
        .o_ctl    (w_ctl)
    );

    rfstm_sorter #(.W(OFF_W)) u_off_sort (
        .i_clk  (i_clk),
        .i_op   (w_ctl.op),
        .i_din  (i_in.freq_offset),
        .o_mean (w_off_mean)
    );

    rfstm_sorter #(.W(STR_W)) u_str_sort (
        .i_clk  (i_clk),
        .i_op   (w_ctl.op),
        .i_din  (i_in.signal_strength[STR_W-1:0]),
        .o_mean (w_str_mean)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_group     <= '0;
            r_flag      <= 1'b0;
        end else begin
            if (w_ctl.direct || w_ctl.fin) begin
                r_out_valid <= 1'b1;
            end else if (w_drain) begin
                r_out_valid <= 1'b0;
            end
            if (w_ctl.fin) begin
                r_group <= w_wrap ? '0 : r_group + 1'b1;
                if (w_wrap) begin
                    r_flag <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.direct) begin
            r_done      <= 1'b0;
            r_str_mean  <= '0;
            r_off_mean  <= '0;
            r_slot      <= '0;
            r_ready_out <= r_flag;
        end else if (w_ctl.fin) begin
            r_done      <= 1'b1;
            r_str_mean  <= w_str_mean;
            r_off_mean  <= w_off_mean;
            r_slot      <= SLOT_W'(r_group);
            r_ready_out <= r_flag || w_wrap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.fin) begin
            r_str_ring[r_group] <= w_str_mean;
            r_off_ring[r_group] <= w_off_mean;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.group_done    = r_done;
    assign o_out.strength_mean = r_str_mean;
    assign o_out.offset_mean   = r_off_mean;
    assign o_out.ring_slot     = r_slot;
    assign o_out.data_ready    = r_ready_out;

`ifndef SYNTHESIS
    a_fin_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.fin |=> r_out_valid && r_done)
        else $error("completed group did not load the output register");

    a_flag_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_flag))
        else $error("data ready flag cleared without reset");

    a_group_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_group <= GW'(RING_DEPTH - 1))
        else $error("ring index beyond ring depth");

    a_last_sample_sorts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !w_ctl.direct |=> !w_idle && !r_out_valid)
        else $error("group end did not start the sort");
`endif

endmodule

// ===== bench/tb_rf_sample_trimmed_mean_unit.sv =====
`timescale 1ns / 1ps

module tb_rf_sample_trimmed_mean_unit;
    import rfstm_pkg::*;

    localparam int RING_SLOTS     = 16;
    localparam int DRAIN_CYCLES   = 80;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic                     group_done;
        logic signed [STR_W-1:0]  strength_mean;
        logic signed [OFF_W-1:0]  offset_mean;
        logic [SLOT_W-1:0]        ring_slot;
        logic                     data_ready;
    } t_mean_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rfstm_in_if  in_if ();
    rfstm_out_if out_if ();

    rf_sample_trimmed_mean_unit #(
        .RING_DEPTH(RING_SLOTS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_mean_result pending_means[$];

    int strength_window[GROUP_SIZE];
    int offset_window[GROUP_SIZE];
    int window_fill;
    int ring_index;
    bit ring_full;
    int groups_seen;
    int ring_wraps;
    int samples_seen;
    int results_checked;
    int fail_count;
    int idle_cycles;
    int gap_pct;
    int stall_pct;
    bit quiet_tail;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int middle_rank_mean(input int vals[GROUP_SIZE]);
        int ranked[GROUP_SIZE];
        int tmp;
        int sum;
        int i;
        int j;
        ranked = vals;
        for (i = 0; i < GROUP_SIZE - 1; i++) begin
            for (j = 0; j < GROUP_SIZE - 1 - i; j++) begin
                if (ranked[j] > ranked[j + 1]) begin
                    tmp = ranked[j];
                    ranked[j] = ranked[j + 1];
                    ranked[j + 1] = tmp;
                end
            end
        end
        sum = 0;
        for (i = int'(MID_FIRST); i <= int'(MID_LAST); i++) begin
            sum += ranked[i];
        end
        return sum >>> 2;
    endfunction

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Prediction runs before checking in the same process, so a transaction
    // accepted on either side at one edge is always seen in a fixed order.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                t_mean_result want;
                want = '0;
                strength_window[window_fill] = 32'($signed(in_if.signal_strength[STR_W-1:0]));
                offset_window[window_fill] = 32'(in_if.freq_offset);
                samples_seen++;
                if (window_fill == GROUP_SIZE - 1) begin
                    want.group_done = 1'b1;
                    want.strength_mean = STR_W'(middle_rank_mean(strength_window));
                    want.offset_mean = OFF_W'(middle_rank_mean(offset_window));
                    want.ring_slot = ring_index[SLOT_W-1:0];
                    groups_seen++;
                    if (ring_index == RING_SLOTS - 1) begin
                        ring_index = 0;
                        ring_full = 1'b1;
                        ring_wraps++;
                    end else begin
                        ring_index++;
                    end
                    window_fill = 0;
                end else begin
                    window_fill++;
                end
                want.data_ready = ring_full;
                pending_means.push_back(want);
            end
            if (out_if.valid && out_if.ready) begin
                if (pending_means.size() == 0) begin
                    fail_count++;
                    $display("%0t: result transaction with nothing expected", $time);
                end else begin
                    t_mean_result want;
                    want = pending_means.pop_front();
                    check_field("group_done", 32'(want.group_done), 32'(out_if.group_done));
                    check_field("strength_mean", 32'(want.strength_mean),
                                32'(out_if.strength_mean));
                    check_field("offset_mean", 32'(want.offset_mean), 32'(out_if.offset_mean));
                    check_field("ring_slot", 32'(want.ring_slot), 32'(out_if.ring_slot));
                    check_field("data_ready", 32'(want.data_ready), 32'(out_if.data_ready));
                    results_checked++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
                    $display("CHECKS FAILED");
                    $finish;
                end
            end
        end
    end

    initial begin
        int window;
        out_if.ready <= 1'b0;
        window = 0;
        forever begin
            @(posedge i_clk);
            if (quiet_tail) begin
                stall_pct = 0;
            end else if (window == 0) begin
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    default: stall_pct = 50;
                endcase
                window = $urandom_range(20, 80);
            end else begin
                window--;
            end
            if ($urandom_range(0, 99) < stall_pct) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
        end
    end

    task automatic send_sample(input logic [15:0] offset, input logic [15:0] strength);
        if ($urandom_range(0, 99) < gap_pct) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.freq_offset <= offset;
        in_if.signal_strength <= strength;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic test_full_scale();
        logic [7:0] high_byte [GROUP_SIZE] = '{8'h00, 8'hFF, 8'h80, 8'h7F,
                                              8'h55, 8'hAA, 8'h01, 8'hFE};
        int i;
        for (i = 0; i < GROUP_SIZE; i++) begin
            send_sample(16'h7FFF, {high_byte[i], 8'h7F});
        end
        for (i = 0; i < GROUP_SIZE; i++) begin
            send_sample(16'h8000, {high_byte[i], 8'h80});
        end
    endtask

    task automatic test_floor_rounding();
        logic [15:0] offsets [GROUP_SIZE] = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFE,
                                            16'hFFFD, 16'hFFFB, 16'h0001, 16'h0000};
        logic [7:0] strengths [GROUP_SIZE] = '{8'h01, 8'hFE, 8'hFF, 8'h80,
                                             8'h7F, 8'hFD, 8'h00, 8'hFC};
        int i;
        for (i = 0; i < GROUP_SIZE; i++) begin
            send_sample(offsets[i], {8'($urandom), strengths[i]});
        end
    endtask

    task automatic test_random_groups(input int count);
        logic [15:0] corner [5] = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h0001};
        logic [15:0] offset;
        logic [15:0] strength;
        int n;
        for (n = 0; n < count; n++) begin
            if (n % 32 == 0) begin
                case ($urandom_range(0, 2))
                    0: gap_pct = 0;
                    1: gap_pct = 15;
                    default: gap_pct = 40;
                endcase
            end
            case ($urandom_range(0, 3))
                0, 1: begin
                    offset = 16'($urandom);
                    strength = 16'($urandom);
                end
                2: begin
                    offset = 16'($signed($urandom_range(0, 16)) - 8);
                    strength = {8'($urandom), 8'($signed($urandom_range(0, 8)) - 4)};
                end
                default: begin
                    offset = corner[$urandom_range(0, 4)];
                    strength = {8'($urandom), corner[$urandom_range(0, 4)][15:8]};
                end
            endcase
            send_sample(offset, strength);
        end
    endtask

    task automatic test_quiet_tail(input int count);
        int n;
        gap_pct = 0;
        quiet_tail = 1'b1;
        for (n = 0; n < count; n++) begin
            send_sample(16'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.freq_offset <= '0;
        in_if.signal_strength <= '0;
        window_fill = 0;
        ring_index = 0;
        ring_full = 1'b0;
        groups_seen = 0;
        ring_wraps = 0;
        samples_seen = 0;
        results_checked = 0;
        fail_count = 0;
        idle_cycles = 0;
        gap_pct = 30;
        stall_pct = 0;
        quiet_tail = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_full_scale();
        test_floor_rounding();
        test_random_groups(440);
        test_quiet_tail(40);
        in_if.valid <= 1'b0;

        while (pending_means.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d samples and %0d checked results in %0d groups.",
                 samples_seen, results_checked, groups_seen);
        $display("The result ring wrapped %0d times with random stalls on both sides.",
                 ring_wraps);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
